### src/pstw_pkg.sv
package pstw_pkg;

    localparam logic [1:0] OP_RECV  = 2'd0;
    localparam logic [1:0] OP_CHECK = 2'd1;
    localparam logic [1:0] OP_QUAL  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [2:0] Q_MODERATE = 3'd2;
    localparam logic [2:0] Q_POOR     = 3'd3;
    localparam logic [2:0] Q_CRITICAL = 3'd4;

    localparam logic REG_BASE_THRESHOLD = 1'b0;
    localparam logic REG_OWN_PEER       = 1'b1;

    localparam logic [23:0] BASE_THRESHOLD_RESET = 24'd3600;
    localparam logic [3:0]  OWN_PEER_RESET       = 4'd0;

    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 4;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  peer;
        logic [31:0] frame_now;
        logic [11:0] connected_mask;
        logic [2:0]  link_quality;
        logic        routing_needed;
    } item_t;

    typedef struct packed {
        logic [3:0] kicked_peer;
        logic       last_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  peer;
        logic        peer_ok;
        logic [31:0] frame;
        logic [11:0] mask;
        logic [2:0]  quality;
        logic        routing;
    } cmd_t;

endpackage

### src/pstw_fifo.sv
module pstw_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### src/pstw_front.sv
module pstw_front #(
    parameter int NUM_PEERS = 12
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pstw_pkg::item_t item,
    output logic           full,
    input  logic           cmd_pop,
    output pstw_pkg::cmd_t cmd,
    output logic           cmd_empty
);

    localparam int CMD_W = $bits(pstw_pkg::cmd_t);

    pstw_pkg::cmd_t   cmd_in;
    logic [CMD_W-1:0] cmd_in_bits;
    logic [CMD_W-1:0] cmd_out_bits;

    // classify the item before it is queued
    always_comb
    begin
        cmd_in.op      = item.func;
        cmd_in.peer    = item.peer;
        cmd_in.peer_ok = ({28'd0, item.peer} < NUM_PEERS);
        cmd_in.frame   = item.frame_now;
        cmd_in.mask    = item.connected_mask;
        cmd_in.quality = item.link_quality;
        cmd_in.routing = item.routing_needed;
    end

    assign cmd_in_bits = cmd_in;
    assign cmd         = pstw_pkg::cmd_t'(cmd_out_bits);

    pstw_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (pstw_pkg::CMD_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cmd_in_bits),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd_out_bits),
        .empty (cmd_empty)
    );

endmodule

### src/pstw_back.sv
module pstw_back #(
    parameter int NUM_PEERS  = 12,
    parameter int FRAME_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_empty,
    input  pstw_pkg::cmd_t    cmd,
    output logic              cmd_pop,
    input  logic              res_full,
    output logic              res_push,
    output pstw_pkg::result_t res_data,
    input  logic [23:0]       base_threshold,
    input  logic [3:0]        own_peer
);

    localparam int IW        = $clog2(NUM_PEERS);
    localparam int CW        = (FRAME_BITS > 27) ? FRAME_BITS : 27;
    localparam int MAX_KICKS = NUM_PEERS - 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_PEERS - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [IW-1:0]         idx_reg;
    logic [IW-1:0]         idx_next;
    logic [IW-1:0]         kicks_reg;
    logic [IW-1:0]         kicks_next;
    logic                  pend_valid_reg;
    logic                  pend_valid_next;
    logic [IW-1:0]         pend_peer_reg;
    logic [IW-1:0]         pend_peer_next;
    logic [FRAME_BITS-1:0] last_heard_reg [NUM_PEERS];
    logic [2:0]            quality_reg [NUM_PEERS];
    logic                  routing_reg [NUM_PEERS];

    logic [FRAME_BITS-1:0] now;
    logic [FRAME_BITS-1:0] stamp;
    logic [31:0]           mask_shift;
    logic                  selected;
    logic                  never_seen;
    logic [25:0]           thr;
    logic [CW-1:0]         thr_x;
    logic [CW-1:0]         thr2_x;
    logic [CW-1:0]         elapsed_x;
    logic                  due;
    logic                  stall;
    logic                  stamp_we;
    logic [IW-1:0]         stamp_waddr;
    logic                  clear_all;
    logic                  qual_we;

    function automatic logic [25:0] scale_threshold(input logic [23:0] b, input logic [2:0] q);
        logic [25:0] r;
        unique case (q)
            pstw_pkg::Q_MODERATE: r = {2'b00, b} + {4'b0000, b[23:2]};
            pstw_pkg::Q_POOR:     r = {2'b00, b} + {3'b000, b[23:1]};
            pstw_pkg::Q_CRITICAL: r = {1'b0, b, 1'b0};
            default:              r = {2'b00, b};
        endcase
        return r;
    endfunction

    assign now        = FRAME_BITS'(cmd.frame);
    assign stamp      = last_heard_reg[idx_reg];
    assign mask_shift = {20'd0, cmd.mask} >> idx_reg;
    assign selected   = mask_shift[0] && ({28'd0, own_peer} != 32'(idx_reg));
    assign never_seen = (stamp == '0);
    assign thr        = scale_threshold(base_threshold, quality_reg[idx_reg]);
    assign thr_x      = CW'(thr);
    assign thr2_x     = CW'({thr, 1'b0});
    assign elapsed_x  = CW'(now - stamp);

    assign due = selected && !never_seen && !(elapsed_x < thr_x)
                 && !(routing_reg[idx_reg] && (elapsed_x < thr2_x))
                 && (32'(kicks_reg) < MAX_KICKS);
    assign stall = due && pend_valid_reg && res_full;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        kicks_next      = kicks_reg;
        pend_valid_next = pend_valid_reg;
        pend_peer_next  = pend_peer_reg;
        cmd_pop         = 1'b0;
        res_push        = 1'b0;
        res_data        = '0;
        stamp_we        = 1'b0;
        stamp_waddr     = idx_reg;
        clear_all       = 1'b0;
        qual_we         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    unique case (cmd.op)
                        pstw_pkg::OP_RECV:
                        begin
                            cmd_pop     = 1'b1;
                            stamp_we    = cmd.peer_ok;
                            stamp_waddr = IW'(cmd.peer);
                        end
                        pstw_pkg::OP_QUAL:
                        begin
                            cmd_pop = 1'b1;
                            qual_we = cmd.peer_ok;
                        end
                        pstw_pkg::OP_CLEAR:
                        begin
                            cmd_pop   = 1'b1;
                            clear_all = 1'b1;
                        end
                        pstw_pkg::OP_CHECK:
                        begin
                            state_next      = ST_WALK;
                            idx_next        = '0;
                            kicks_next      = '0;
                            pend_valid_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (!stall)
                begin
                    if (selected && never_seen)
                    begin
                        stamp_we = 1'b1;
                    end
                    if (due)
                    begin
                        stamp_we        = 1'b1;
                        kicks_next      = kicks_reg + 1'b1;
                        pend_peer_next  = idx_reg;
                        pend_valid_next = 1'b1;
                        if (pend_valid_reg)
                        begin
                            res_push             = 1'b1;
                            res_data.kicked_peer = 4'(pend_peer_reg);
                            res_data.last_of_run = 1'b0;
                        end
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                // the held kick is the final one of the run
                if (!pend_valid_reg)
                begin
                    cmd_pop    = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (!res_full)
                begin
                    res_push             = 1'b1;
                    res_data.kicked_peer = 4'(pend_peer_reg);
                    res_data.last_of_run = 1'b1;
                    pend_valid_next      = 1'b0;
                    cmd_pop              = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            kicks_reg      <= '0;
            pend_valid_reg <= 1'b0;
            pend_peer_reg  <= '0;
            for (int i = 0; i < NUM_PEERS; i++)
            begin
                last_heard_reg[i] <= '0;
                quality_reg[i]    <= '0;
                routing_reg[i]    <= 1'b0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            kicks_reg      <= kicks_next;
            pend_valid_reg <= pend_valid_next;
            pend_peer_reg  <= pend_peer_next;
            if (clear_all)
            begin
                for (int i = 0; i < NUM_PEERS; i++)
                begin
                    last_heard_reg[i] <= '0;
                end
            end
            else if (stamp_we)
            begin
                last_heard_reg[stamp_waddr] <= now;
            end
            if (qual_we)
            begin
                quality_reg[IW'(cmd.peer)] <= cmd.quality;
                routing_reg[IW'(cmd.peer)] <= cmd.routing;
            end
        end
    end

endmodule

### src/peer_stall_watchdog.sv
// per-peer stall watchdog
// items enter on push/full; each item is accepted when push is high and full low
// func selects receive stamp, stall check, quality update or clear of all stamps
// results leave on empty/pop: the oldest kick sits on result while empty is low
// and is taken when pop is high; only a check gives results, one per kicked peer,
// in rising peer order, with last_of_run set on the final kick of that check
// a two-entry item queue decouples the front from the back, so items keep
// being taken while the back works or waits on the receiver
// receive, quality and clear items are each handled and popped in the idle state
// a check moves the back from idle through a walk over every peer entry to a flush,
// whether or not it kicks; each kick is held until the next one is found, so a
// run's final kick is pushed from the flush, where the check item is popped too
// a full result queue stalls the walk in place while a held kick must be pushed,
// and it holds the flush; nothing is dropped
// reset clears all stamps, quality levels and routing flags and loads
// base_threshold 3600 and own_peer 0; configuration is written via cfg_we
module peer_stall_watchdog #(
    parameter int NUM_PEERS  = 12,
    parameter int FRAME_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pstw_pkg::item_t   item,
    output logic              full,
    output logic              empty,
    input  logic              pop,
    output pstw_pkg::result_t result,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [23:0]       cfg_data
);

    localparam int RES_W = $bits(pstw_pkg::result_t);

    logic [23:0]       base_threshold_reg;
    logic [3:0]        own_peer_reg;
    pstw_pkg::cmd_t    cmd;
    logic              cmd_empty;
    logic              cmd_pop;
    logic              res_full;
    logic              res_push;
    pstw_pkg::result_t res_data;
    logic [RES_W-1:0]  res_in_bits;
    logic [RES_W-1:0]  res_out_bits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_threshold_reg <= pstw_pkg::BASE_THRESHOLD_RESET;
            own_peer_reg       <= pstw_pkg::OWN_PEER_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pstw_pkg::REG_BASE_THRESHOLD: base_threshold_reg <= cfg_data;
                pstw_pkg::REG_OWN_PEER:       own_peer_reg       <= cfg_data[3:0];
            endcase
        end
    end

    pstw_front #(
        .NUM_PEERS (NUM_PEERS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .cmd_empty (cmd_empty)
    );

    pstw_back #(
        .NUM_PEERS  (NUM_PEERS),
        .FRAME_BITS (FRAME_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_empty      (cmd_empty),
        .cmd            (cmd),
        .cmd_pop        (cmd_pop),
        .res_full       (res_full),
        .res_push       (res_push),
        .res_data       (res_data),
        .base_threshold (base_threshold_reg),
        .own_peer       (own_peer_reg)
    );

    assign res_in_bits = res_data;
    assign result      = pstw_pkg::result_t'(res_out_bits);

    pstw_fifo #(
        .WIDTH (RES_W),
        .DEPTH (pstw_pkg::RES_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in_bits),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_out_bits),
        .empty (empty)
    );

endmodule

### src/pstw_checker.sv
module pstw_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              push,
    input logic              full,
    input logic              empty,
    input logic              pop,
    input pstw_pkg::result_t result
);

    // kicked peer stays inside the peer table
    a_peer_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.kicked_peer < 4'd12))
        else $error("kicked peer out of range");

    // a waiting result holds until it is taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed");

    // the item queue can only fill through a push
    a_full_by_push: assert property (@(posedge clk) disable iff (!rst_n)
        (!full && !push) |=> !full)
        else $error("full rose without push");

    // kicks within one check come in rising peer order
    a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !result.last_of_run)
        |=> (empty || (result.kicked_peer > $past(result.kicked_peer))))
        else $error("kick order broken within run");

endmodule

bind peer_stall_watchdog pstw_checker u_pstw_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
